// File: sv/pwmap_pkg.sv
// ----------------------------------------------------------------------------
// PWM audio sample player package
// Shared types, sizes and helper functions for the sample player.
// ----------------------------------------------------------------------------
package pwmap_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W     = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned FILL_OUT_W = 8;

  localparam logic [SAMPLE_W-1:0] DUTY_RESET = 8'd127;

  // Output queue between the pipeline and the result channel.
  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_IDX_W = 2;
  localparam int unsigned OQ_CNT_W = 2;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [5:0]            duty_high;
    logic [1:0]            duty_low;
    logic                  sample_played;
    logic [FILL_OUT_W-1:0] fill_level;
    logic                  playing;
  } out_item_t;

  // Access to the sample ring for one cycle.
  typedef struct packed {
    logic                we;
    logic [PTR_W-1:0]    waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic [PTR_W-1:0]    raddr;
  } ring_req_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

  function automatic logic [FILL_OUT_W-1:0] ring_fill(input logic [PTR_W-1:0] wp,
                                                      input logic [PTR_W-1:0] rp);
    logic [FILL_W-1:0] fill;
    if (wp >= rp) begin
      fill = FILL_W'(wp) - FILL_W'(rp);
    end else begin
      fill = FILL_W'(RING_DEPTH) - FILL_W'(rp) + FILL_W'(wp);
    end
    if (fill > FILL_W'(255)) begin
      return 8'hFF;
    end
    return fill[FILL_OUT_W-1:0];
  endfunction

endpackage

// File: sv/pwm_audio_sample_player.sv
// ----------------------------------------------------------------------------
// PWM audio sample player
// Ring buffer of audio samples feeding the duty register of a PWM DAC.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall_o is low, pushes and
// timer ticks alike, and delivers one result per item through the stage 1
// register and the output queue. Pointers, the rate timer and playback control
// are updated in the cycle of acceptance; the sample for a serviced overflow
// comes from the single read port of the ring memory in the following cycle,
// in step with stage 1. Results wait in a three-entry queue. In a full-rate
// stream the input is stalled from the cycle after the first cycle in which the
// output side stalls, and it flows again in the cycle after a result leaves the
// queue. The ring holds RING_DEPTH - 1 samples; a push into a full ring is dropped
// and reported as not accepted. The user must write the sample-rate reload value
// through the configuration channel while the block is idle; it is not enforced.
module pwm_audio_sample_player (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pwmap_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pwmap_pkg::out_item_t              out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pwmap_pkg::TIMER_W-1:0]     cfg_data_i
);

  typedef struct packed {
    logic                                 valid;
    logic                                 accepted;
    logic                                 played;
    logic [pwmap_pkg::FILL_OUT_W-1:0]     fill;
    logic                                 playing;
  } s1_t;

  logic [pwmap_pkg::PTR_W-1:0]    wp_q, wp_d, rp_q, rp_d, wp_nxt;
  logic [pwmap_pkg::TIMER_W-1:0]  timer_q, timer_d, timer_inc, reload_q;
  logic                           pend_q, pend_d, en_q, en_d;
  logic [pwmap_pkg::SAMPLE_W-1:0] duty_q, duty_cur, ring_rdata;
  logic                           in_acc, out_pop, push_ok, tick_serv, play;
  s1_t                            s1_q, s1_d;
  pwmap_pkg::ring_req_t           ring_req;
  pwmap_pkg::out_item_t           res;

  pwmap_pkg::out_item_t             oq_mem [pwmap_pkg::OQ_DEPTH];
  logic [pwmap_pkg::OQ_IDX_W-1:0]   oq_wr_q, oq_rd_q;
  logic [pwmap_pkg::OQ_CNT_W-1:0]   oq_cnt_q;
  logic [2:0]                       occupancy;

  assign cfg_ready_o = 1'b1;

  // Room is reserved for every transaction still in the pipeline.
  assign occupancy  = {1'b0, oq_cnt_q} + {2'b00, s1_q.valid};
  assign in_stall_o = (occupancy >= 3'(pwmap_pkg::OQ_DEPTH));
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_valid_o = (oq_cnt_q != '0);
  assign out_pop    = out_valid_o & ~out_stall_i;
  assign out_item_o = oq_mem[oq_rd_q];

  // Stage 0: control state update.
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    timer_d   = timer_q;
    pend_d    = pend_q;
    en_d      = en_q;
    push_ok   = 1'b0;
    tick_serv = 1'b0;
    play      = 1'b0;
    wp_nxt    = pwmap_pkg::ring_next(wp_q);
    timer_inc = timer_q + pwmap_pkg::TIMER_W'(1);
    if (in_acc) begin
      if (in_item_i.kind == pwmap_pkg::KIND_PUSH) begin
        if (wp_nxt != rp_q) begin
          push_ok = 1'b1;
          wp_d    = wp_nxt;
          en_d    = 1'b1;
        end
      end else begin
        timer_d = timer_inc;
        if (timer_inc == '0) begin
          pend_d = 1'b1;
        end
        if ((pend_q || (timer_inc == '0)) && en_q) begin
          tick_serv = 1'b1;
          timer_d   = reload_q;
          pend_d    = 1'b0;
          if (rp_q != wp_q) begin
            play = 1'b1;
            rp_d = pwmap_pkg::ring_next(rp_q);
          end
          if (rp_d == wp_q) begin
            en_d = 1'b0;
          end
        end
      end
    end
    s1_d.valid    = in_acc;
    s1_d.accepted = push_ok;
    s1_d.played   = play;
    s1_d.fill     = pwmap_pkg::ring_fill(wp_d, rp_d);
    s1_d.playing  = en_d;
  end

  // The read port always looks at the oldest sample; its data lines up with stage 1.
  assign ring_req.we    = push_ok;
  assign ring_req.waddr = wp_q;
  assign ring_req.wdata = in_item_i.sample;
  assign ring_req.raddr = rp_q;

  pwmap_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  // Stage 1: the duty register picks up the popped sample.
  assign duty_cur = s1_q.played ? ring_rdata : duty_q;

  always_comb begin
    res.accepted      = s1_q.accepted;
    res.duty_high     = duty_cur[7:2];
    res.duty_low      = duty_cur[1:0];
    res.sample_played = s1_q.played;
    res.fill_level    = s1_q.fill;
    res.playing       = s1_q.playing;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      timer_q  <= '0;
      pend_q   <= 1'b0;
      en_q     <= 1'b0;
      reload_q <= '0;
      duty_q   <= pwmap_pkg::DUTY_RESET;
      s1_q     <= '0;
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      timer_q <= timer_d;
      pend_q  <= pend_d;
      en_q    <= en_d;
      s1_q    <= s1_d;
      duty_q  <= duty_cur;
      if (cfg_valid_i && cfg_ready_o) begin
        reload_q <= cfg_data_i;
      end
      if (s1_q.valid) begin
        oq_wr_q <= (oq_wr_q == pwmap_pkg::OQ_IDX_W'(pwmap_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_wr_q + pwmap_pkg::OQ_IDX_W'(1);
      end
      if (out_pop) begin
        oq_rd_q <= (oq_rd_q == pwmap_pkg::OQ_IDX_W'(pwmap_pkg::OQ_DEPTH - 1)) ?
                   '0 : oq_rd_q + pwmap_pkg::OQ_IDX_W'(1);
      end
      oq_cnt_q <= oq_cnt_q + pwmap_pkg::OQ_CNT_W'(s1_q.valid)
                           - pwmap_pkg::OQ_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      oq_mem[oq_wr_q] <= res;
    end
  end

`ifndef SYNTHESIS
  // Playback is never left enabled on an empty ring.
  a_no_enable_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en_q && (rp_q == wp_q)))
    else $error("playback enabled with an empty ring");

  // The queue always has room for the transaction leaving stage 1.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= 3'(pwmap_pkg::OQ_DEPTH))
    else $error("output queue overrun");

  // A played sample always advances the read pointer by one slot.
  a_play_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play |=> (rp_q == pwmap_pkg::ring_next($past(rp_q))))
    else $error("read pointer did not advance on play");

  // A sample is only played when an overflow is serviced.
  a_play_needs_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play |-> tick_serv)
    else $error("sample played without a serviced overflow");

  // Pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wp_q) < pwmap_pkg::RING_DEPTH) && (32'(rp_q) < pwmap_pkg::RING_DEPTH))
    else $error("ring pointer out of range");
`endif

endmodule

// File: sv/pwmap_ring.sv
// ----------------------------------------------------------------------------
// Sample ring memory
// Single-port-write, single-port-read sample store with a registered read.
// ----------------------------------------------------------------------------
module pwmap_ring (
  input  logic                             clk_i,
  input  pwmap_pkg::ring_req_t             req_i,
  output logic [pwmap_pkg::SAMPLE_W-1:0]   rdata_o
);

  logic [pwmap_pkg::SAMPLE_W-1:0] mem [pwmap_pkg::RING_DEPTH];
  logic [pwmap_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
